/* design/assert_macros.svh */
// Assertion macros for the dense layer design; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on the rising edge of a given clock, off while reset is low
`define FPDL_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock, off while reset is low
`define FPDL_ASSERT(lbl, prop, msg) \
    `FPDL_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`else

`define FPDL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define FPDL_ASSERT(lbl, prop, msg)

`endif

`endif

/* design/fpdl_pkg.sv */
// Shared types, codes and helpers for the fixed-point dense layer.
package fpdl_pkg;

    // Fixed widths of the datapath
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int NIN_W      = 9;
    localparam int NOUT_W     = 7;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FN_WEIGHT = 2'd0,
        FN_BIAS   = 2'd1,
        FN_ACT    = 2'd2
    } t_func;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_COUNT  = 3'd0,
        CFG_OUTPUT_COUNT = 3'd1,
        CFG_OUTPUT_SHIFT = 3'd2,
        CFG_BIAS_SHIFT   = 3'd3,
        CFG_BIAS_ENABLE  = 3'd4,
        CFG_RELU_ENABLE  = 3'd5
    } t_cfg_idx;

    // Row sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_BINIT,
        ST_MAC,
        ST_DRAIN,
        ST_SHIFT,
        ST_PACK
    } t_state;

    // Decoded shift: direction and magnitude
    typedef struct packed {
        logic       left;
        logic [5:0] amt;
    } t_shift;

    // Split a 7-bit signed shift into direction and magnitude, -64 saturates to 63
    function automatic t_shift decode_shift(input logic [6:0] sh);
        t_shift     d;
        logic [6:0] neg;
        neg = 7'(~sh + 7'd1);
        if (sh[6]) begin
            d.left = 1'b0;
            d.amt  = neg[6] ? 6'd63 : neg[5:0];
        end else begin
            d.left = 1'b1;
            d.amt  = sh[5:0];
        end
        return d;
    endfunction

endpackage

/* design/fpdl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fpdl_ram
    import fpdl_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/fixed_point_dense_layer.sv */
// Fixed-point dense layer: weight/bias/activation stores and a shared MAC sequencer.
// Load items (weight, bias, non-last activation) are taken one per cycle while idle.
// A last activation runs each output row in turn: one 16x16 multiply-accumulate per
// cycle over the inputs, plus bias fetch, pipeline drain and rescale.
// Input is not ready while a row runs; results leave through one output register.
// Synchronous active-low reset clears the sequencer, accumulator, configuration registers and
// output valid flag; the stores hold no reset and must be written before they are read.
`include "assert_macros.svh"

module fixed_point_dense_layer
    import fpdl_pkg::*;
#(
    parameter int MAX_INPUTS  = 256,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // row_index[5:0], col_index[13:6], value[29:14]
    input  logic [1:0]            s_axis_tuser,   // func[1:0]
    input  logic                  s_axis_tlast,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // out_index[5:0], result_value[21:6]
    output logic                  m_axis_tuser,   // overflow[0]
    output logic                  m_axis_tlast
);

    localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int WD  = MAX_INPUTS * MAX_OUTPUTS;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

    // Configuration registers
    logic [NIN_W-1:0]  r_input_count;
    logic [NOUT_W-1:0] r_output_count;
    logic [6:0]        r_output_shift;
    logic [6:0]        r_bias_shift;
    logic              r_bias_enable;
    logic              r_relu_enable;

    // Sequencer
    t_state            r_state, n_state;
    logic [NIN_W-1:0]  r_nin, r_i;
    logic [NOUT_W-1:0] r_nout, r_o;
    logic              r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [DATA_W-1:0] r_sh_val;
    logic              r_ovf;

    // Output register
    logic              r_m_valid;
    logic [ROW_W-1:0]  r_out_index;
    logic [DATA_W-1:0] r_res;
    logic              r_res_ovf;
    logic              r_res_last;

    // Input fields
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [DATA_W-1:0] in_value;
    logic              in_xfer;
    logic              start_row;

    // Control strobes
    logic              issue_mac;
    logic              load_bias;
    logic              do_shift;
    logic              pack_go;
    logic              o_done;
    logic              i_done;

    // Store ports
    logic              w_we, b_we, a_we;
    logic [WAW-1:0]    w_waddr, w_raddr;
    logic [OW-1:0]     b_waddr, b_raddr;
    logic [IW-1:0]     a_waddr, a_raddr;
    logic [DATA_W-1:0] w_rd, b_rd, a_rd;

    // Datapath helpers
    t_shift            os_dec, bs_dec;
    logic [ACC_W-1:0]  bias_ext, bias_l, bias_init;
    logic signed [ACC_W-1:0] bias_r;
    logic [ACC_W-1:0]  acc_l;
    logic signed [ACC_W-1:0] acc_r, probe;
    logic [6:0]        probe_k;
    logic              probe_fits, left_big, ovf_calc;
    logic              relu_zero;
    logic [NIN_W-1:0]  nin_sat;
    logic [NOUT_W-1:0] nout_sat;

    assign in_row    = s_axis_tdata[5:0];
    assign in_col    = s_axis_tdata[13:6];
    assign in_value  = s_axis_tdata[29:14];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign start_row = in_xfer && (s_axis_tuser == FN_ACT) && s_axis_tlast;

    assign o_cfg_ready = 1'b1;

    // Take configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= NIN_W'(256);
            r_output_count <= NOUT_W'(64);
            r_output_shift <= '0;
            r_bias_shift   <= '0;
            r_bias_enable  <= 1'b0;
            r_relu_enable  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INPUT_COUNT:  r_input_count  <= i_cfg_data[NIN_W-1:0];
                CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data[NOUT_W-1:0];
                CFG_OUTPUT_SHIFT: r_output_shift <= i_cfg_data[6:0];
                CFG_BIAS_SHIFT:   r_bias_shift   <= i_cfg_data[6:0];
                CFG_BIAS_ENABLE:  r_bias_enable  <= i_cfg_data[0];
                CFG_RELU_ENABLE:  r_relu_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the counts into the store range
    always_comb begin
        if (r_input_count == '0) begin
            nin_sat = NIN_W'(1);
        end else if (32'(r_input_count) > MAX_INPUTS) begin
            nin_sat = NIN_W'(MAX_INPUTS);
        end else begin
            nin_sat = r_input_count;
        end
        if (r_output_count == '0) begin
            nout_sat = NOUT_W'(1);
        end else if (32'(r_output_count) > MAX_OUTPUTS) begin
            nout_sat = NOUT_W'(MAX_OUTPUTS);
        end else begin
            nout_sat = r_output_count;
        end
    end

    // Store write decode from accepted load items
    always_comb begin
        w_we    = in_xfer && (s_axis_tuser == FN_WEIGHT) && (32'(in_row) < MAX_OUTPUTS)
                  && (32'(in_col) < MAX_INPUTS);
        b_we    = in_xfer && (s_axis_tuser == FN_BIAS) && (32'(in_row) < MAX_OUTPUTS);
        a_we    = in_xfer && (s_axis_tuser == FN_ACT) && (32'(in_col) < MAX_INPUTS);
        w_waddr = WAW'(32'(in_row) * MAX_INPUTS + 32'(in_col));
        b_waddr = OW'(in_row);
        a_waddr = IW'(in_col);
        w_raddr = WAW'(32'(r_o) * MAX_INPUTS + 32'(r_i));
        b_raddr = OW'(r_o);
        a_raddr = IW'(r_i);
    end

    fpdl_ram #(.WIDTH(DATA_W), .DEPTH(WD)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (in_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    fpdl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (in_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rd)
    );

    fpdl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_INPUTS)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (in_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rd)
    );

    assign i_done = (r_i == r_nin - NIN_W'(1));
    assign o_done = (r_o == r_nout - NOUT_W'(1));

    // Next state of the row sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start_row) n_state = ST_BIAS;
            ST_BIAS:  n_state = ST_BINIT;
            ST_BINIT: n_state = ST_MAC;
            ST_MAC:   if (i_done) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_v1) n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_PACK;
            ST_PACK: begin
                if (pack_go) n_state = o_done ? ST_IDLE : ST_BIAS;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Strobes decoded from the state
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        issue_mac     = (r_state == ST_MAC);
        load_bias     = (r_state == ST_BINIT);
        do_shift      = (r_state == ST_SHIFT);
        pack_go       = (r_state == ST_PACK) && (!r_m_valid || m_axis_tready);
    end

    // Bias rescale into the accumulator format
    always_comb begin
        bs_dec    = decode_shift(r_bias_shift);
        bias_ext  = {{(ACC_W-DATA_W){b_rd[DATA_W-1]}}, b_rd};
        bias_l    = bias_ext << bs_dec.amt;
        bias_r    = $signed(bias_ext) >>> bs_dec.amt;
        bias_init = bs_dec.left ? bias_l : bias_r;
    end

    // Output rescale and range probe
    always_comb begin
        os_dec     = decode_shift(r_output_shift);
        acc_l      = r_acc << os_dec.amt;
        acc_r      = $signed(r_acc) >>> os_dec.amt;
        left_big   = os_dec.left && (32'(os_dec.amt) >= DATA_W);
        probe_k    = os_dec.left ? (7'(DATA_W - 1) - {1'b0, os_dec.amt})
                                 : ({1'b0, os_dec.amt} + 7'(DATA_W - 1));
        probe      = $signed(r_acc) >>> probe_k;
        probe_fits = (probe == '0) || (probe == '1);
        ovf_calc   = left_big ? (r_acc != '0) : !probe_fits;
        relu_zero  = r_relu_enable && (r_acc[ACC_W-1] || (r_acc == '0));
    end

    // Sequencer state, counters and read pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_i     <= '0;
            r_o     <= '0;
            r_nin   <= NIN_W'(1);
            r_nout  <= NOUT_W'(1);
        end else begin
            r_state <= n_state;
            r_v1    <= issue_mac;
            r_v2    <= r_v1;
            if (start_row) begin
                r_nin  <= nin_sat;
                r_nout <= nout_sat;
                r_o    <= '0;
            end
            if (load_bias) begin
                r_i <= '0;
            end else if (issue_mac) begin
                r_i <= r_i + NIN_W'(1);
            end
            if (pack_go) begin
                r_o <= r_o + NOUT_W'(1);
            end
        end
    end

    // Multiply, then accumulate with wrap at the accumulator width
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_rd) * $signed(a_rd);
        if (do_shift) begin
            r_sh_val <= os_dec.left ? acc_l[DATA_W-1:0] : acc_r[DATA_W-1:0];
            r_ovf    <= ovf_calc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (load_bias) begin
            r_acc <= r_bias_enable ? bias_init : '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Output register: load on pack, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (pack_go) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pack_go) begin
            r_out_index <= r_o[ROW_W-1:0];
            r_res       <= relu_zero ? '0 : r_sh_val;
            r_res_ovf   <= relu_zero ? 1'b0 : r_ovf;
            r_res_last  <= o_done;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_res, r_out_index};
    assign m_axis_tuser  = r_res_ovf;
    assign m_axis_tlast  = r_res_last;

    // Product follows each read in the next cycle
    `FPDL_ASSERT(a_pipe_follow, r_v1 |=> r_v2, "read pipeline lost a product")
    // No read pipeline activity while idle
    `FPDL_ASSERT(a_idle_quiet, (r_state == ST_IDLE) |-> (!r_v1 && !r_v2), "pipeline busy in idle")
    // Accumulator holds while idle
    `FPDL_ASSERT(a_acc_hold, (r_state == ST_IDLE) |=> $stable(r_acc), "accumulator moved in idle")
    // A free output register is always loaded from pack
    `FPDL_ASSERT(a_pack_load, ((r_state == ST_PACK) && !r_m_valid) |=> r_m_valid, "pack stalled")

endmodule
